@@ src/rso_pkg.sv @@
`default_nettype none
package rso_pkg;
    localparam int COORD_W    = 20;
    localparam int SUM_W      = 30;
    localparam int SQ_W       = 50;
    localparam int CNT_W      = 11;
    localparam int MAX_ATOMS  = 1024;
    localparam int MAX_DIGITS = 15;
    localparam int DIG_W      = 4;
    localparam int KEY_W      = 45;
    localparam int NUM_W      = 62;
    localparam int D10_W      = 66;
    localparam int RES_W      = 80;
    localparam int NUM_TERMS  = 5;
    localparam int STEP_W     = 3;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic             ovf;
        logic [SUM_W-1:0] sx;
        logic [SUM_W-1:0] sy;
        logic [SUM_W-1:0] sz;
        logic [SQ_W-1:0]  sxx;
        logic [SQ_W-1:0]  syy;
        logic [SQ_W-1:0]  sxy;
        logic [SQ_W-1:0]  syz;
        logic [SQ_W-1:0]  sxz;
    } snap_t;
endpackage
`default_nettype wire

@@ src/rso_front.sv @@
`default_nettype none
module rso_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [rso_pkg::COORD_W-1:0]  x_coord,
    input  wire logic signed [rso_pkg::COORD_W-1:0]  y_coord,
    input  wire logic signed [rso_pkg::COORD_W-1:0]  z_coord,
    input  wire logic                                last_atom,
    input  wire logic                                q_full,
    output logic                                     push,
    output rso_pkg::snap_t                           push_data
);
    logic [rso_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic                             ovf_reg, ovf_next;
    logic signed [rso_pkg::SUM_W-1:0] sx_reg, sy_reg, sz_reg, sx_next, sy_next, sz_next;
    logic signed [rso_pkg::SQ_W-1:0]  sxx_reg, syy_reg, sxy_reg, syz_reg, sxz_reg;
    logic signed [rso_pkg::SQ_W-1:0]  sxx_next, syy_next, sxy_next, syz_next, sxz_next;
    logic signed [2*rso_pkg::COORD_W-1:0] pxx, pyy, pxy, pyz, pxz;
    logic accept;
    logic room;

    assign in_stall = q_full;
    assign accept   = in_valid & ~q_full;
    assign push     = accept & last_atom;
    assign room     = cnt_reg < rso_pkg::CNT_W'(rso_pkg::MAX_ATOMS);

    assign pxx = x_coord * x_coord;
    assign pyy = y_coord * y_coord;
    assign pxy = x_coord * y_coord;
    assign pyz = y_coord * z_coord;
    assign pxz = x_coord * z_coord;

    always_comb
    begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        sx_next  = sx_reg;
        sy_next  = sy_reg;
        sz_next  = sz_reg;
        sxx_next = sxx_reg;
        syy_next = syy_reg;
        sxy_next = sxy_reg;
        syz_next = syz_reg;
        sxz_next = sxz_reg;
        if (room)
        begin
            cnt_next = cnt_reg + 1'b1;
            sx_next  = sx_reg + rso_pkg::SUM_W'(x_coord);
            sy_next  = sy_reg + rso_pkg::SUM_W'(y_coord);
            sz_next  = sz_reg + rso_pkg::SUM_W'(z_coord);
            sxx_next = sxx_reg + rso_pkg::SQ_W'(pxx);
            syy_next = syy_reg + rso_pkg::SQ_W'(pyy);
            sxy_next = sxy_reg + rso_pkg::SQ_W'(pxy);
            syz_next = syz_reg + rso_pkg::SQ_W'(pyz);
            sxz_next = sxz_reg + rso_pkg::SQ_W'(pxz);
        end
        else
        begin
            ovf_next = 1'b1;
        end
    end

    always_comb
    begin
        push_data.n   = cnt_next;
        push_data.ovf = ovf_next;
        push_data.sx  = sx_next;
        push_data.sy  = sy_next;
        push_data.sz  = sz_next;
        push_data.sxx = sxx_next;
        push_data.syy = syy_next;
        push_data.sxy = sxy_next;
        push_data.syz = syz_next;
        push_data.sxz = sxz_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sz_reg  <= '0;
            sxx_reg <= '0;
            syy_reg <= '0;
            sxy_reg <= '0;
            syz_reg <= '0;
            sxz_reg <= '0;
        end
        else if (accept)
        begin
            if (last_atom)
            begin
                cnt_reg <= '0;
                ovf_reg <= 1'b0;
                sx_reg  <= '0;
                sy_reg  <= '0;
                sz_reg  <= '0;
                sxx_reg <= '0;
                syy_reg <= '0;
                sxy_reg <= '0;
                syz_reg <= '0;
                sxz_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_next;
                ovf_reg <= ovf_next;
                sx_reg  <= sx_next;
                sy_reg  <= sy_next;
                sz_reg  <= sz_next;
                sxx_reg <= sxx_next;
                syy_reg <= syy_next;
                sxy_reg <= sxy_next;
                syz_reg <= syz_next;
                sxz_reg <= sxz_next;
            end
        end
    end
endmodule
`default_nettype wire

@@ src/rso_queue.sv @@
`default_nettype none
module rso_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire rso_pkg::snap_t push_data,
    output logic                full,
    output logic                not_empty,
    input  wire logic           pop,
    output rso_pkg::snap_t      pop_data
);
    rso_pkg::snap_t mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign pop_data  = mem_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

@@ src/rso_back.sv @@
`default_nettype none
module rso_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_valid,
    input  wire rso_pkg::snap_t               q_data,
    output logic                              pop,
    input  wire logic [rso_pkg::DIG_W-1:0]    digits,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [rso_pkg::KEY_W-1:0]         octkey,
    output logic [rso_pkg::CNT_W-1:0]         atom_count,
    output logic                              too_many
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_INIT = 3'd2;
    localparam logic [2:0] S_LVL  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]                     state_reg;
    logic [rso_pkg::STEP_W-1:0]     step_reg;
    logic [rso_pkg::DIG_W-1:0]      lv_reg, dsat;
    rso_pkg::snap_t                 w_reg;
    logic signed [rso_pkg::SQ_W-1:0]   mul_a;
    logic signed [rso_pkg::SUM_W-1:0]  mul_u, mul_v;
    logic signed [rso_pkg::CNT_W+rso_pkg::SQ_W:0] na_prod;
    logic signed [2*rso_pkg::SUM_W-1:0]           uv_prod;
    logic signed [rso_pkg::NUM_W-1:0]  p1_reg, p2_reg;
    logic signed [rso_pkg::NUM_W-1:0]  res_reg [rso_pkg::NUM_TERMS];
    logic signed [rso_pkg::RES_W-1:0]  r0_reg, r1_reg, r2_reg, r0_next, r1_next, r2_next;
    logic signed [rso_pkg::D10_W-1:0]  d10x_reg, d10y_reg;
    logic signed [rso_pkg::D10_W-1:0]  denx_e, deny_e;
    logic [rso_pkg::KEY_W-1:0]      key_reg;
    logic                           m0, m1, m2;
    logic                           out_valid_reg, out_valid_next, out_free;
    logic [rso_pkg::KEY_W-1:0]      octkey_reg;
    logic [rso_pkg::CNT_W-1:0]      count_reg;
    logic                           many_reg;

    assign dsat = (digits > rso_pkg::DIG_W'(rso_pkg::MAX_DIGITS))
                ? rso_pkg::DIG_W'(rso_pkg::MAX_DIGITS) : digits;
    assign pop  = (state_reg == S_IDLE) && q_valid;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        mul_a = $signed(w_reg.sxy);
        mul_u = $signed(w_reg.sx);
        mul_v = $signed(w_reg.sy);
        unique case (step_reg)
            3'd0:
            begin
                mul_a = $signed(w_reg.sxy);
                mul_u = $signed(w_reg.sx);
                mul_v = $signed(w_reg.sy);
            end
            3'd1:
            begin
                mul_a = $signed(w_reg.syz);
                mul_u = $signed(w_reg.sy);
                mul_v = $signed(w_reg.sz);
            end
            3'd2:
            begin
                mul_a = $signed(w_reg.sxz);
                mul_u = $signed(w_reg.sx);
                mul_v = $signed(w_reg.sz);
            end
            3'd3:
            begin
                mul_a = $signed(w_reg.sxx);
                mul_u = $signed(w_reg.sx);
                mul_v = $signed(w_reg.sx);
            end
            3'd4:
            begin
                mul_a = $signed(w_reg.syy);
                mul_u = $signed(w_reg.sy);
                mul_v = $signed(w_reg.sy);
            end
            default:
            begin
                mul_a = $signed(w_reg.sxy);
                mul_u = $signed(w_reg.sx);
                mul_v = $signed(w_reg.sy);
            end
        endcase
    end

    assign na_prod = $signed({1'b0, w_reg.n}) * mul_a;
    assign uv_prod = mul_u * mul_v;

    assign denx_e = rso_pkg::D10_W'(res_reg[3]);
    assign deny_e = rso_pkg::D10_W'(res_reg[4]);

    // r = num*2^(l-1) - 10*den*q(l); bit is r > 0
    assign m0 = r0_reg > 0;
    assign m1 = r1_reg > 0;
    assign m2 = r2_reg > 0;
    assign r0_next = (r0_reg <<< 1) + (m0 ? -rso_pkg::RES_W'(d10x_reg) : rso_pkg::RES_W'(d10x_reg));
    assign r1_next = (r1_reg <<< 1) + (m1 ? -rso_pkg::RES_W'(d10y_reg) : rso_pkg::RES_W'(d10y_reg));
    assign r2_next = (r2_reg <<< 1) + (m2 ? -rso_pkg::RES_W'(d10x_reg) : rso_pkg::RES_W'(d10x_reg));

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (state_reg == S_OUT && out_free)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            w_reg <= q_data;
        if (state_reg == S_MUL)
        begin
            p1_reg <= rso_pkg::NUM_W'(na_prod);
            p2_reg <= rso_pkg::NUM_W'(uv_prod);
            if (step_reg != '0)
                res_reg[step_reg - 1'b1] <= p1_reg - p2_reg;
        end
        if (state_reg == S_INIT)
        begin
            r0_reg   <= rso_pkg::RES_W'(res_reg[0]);
            r1_reg   <= rso_pkg::RES_W'(res_reg[1]);
            r2_reg   <= rso_pkg::RES_W'(res_reg[2]);
            d10x_reg <= (denx_e <<< 3) + (denx_e <<< 1);
            d10y_reg <= (deny_e <<< 3) + (deny_e <<< 1);
            key_reg  <= '0;
        end
        if (state_reg == S_LVL && lv_reg != dsat)
        begin
            r0_reg  <= r0_next;
            r1_reg  <= r1_next;
            r2_reg  <= r2_next;
            key_reg <= {key_reg[rso_pkg::KEY_W-4:0], m2, m1, m0};
        end
        if (state_reg == S_OUT && out_free)
        begin
            octkey_reg <= key_reg;
            count_reg  <= w_reg.n;
            many_reg   <= w_reg.ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            lv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == rso_pkg::STEP_W'(rso_pkg::NUM_TERMS))
                        state_reg <= S_INIT;
                end
                S_INIT:
                begin
                    lv_reg    <= '0;
                    state_reg <= S_LVL;
                end
                S_LVL:
                begin
                    if (lv_reg == dsat)
                        state_reg <= S_OUT;
                    else
                        lv_reg <= lv_reg + 1'b1;
                end
                S_OUT:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign octkey     = octkey_reg;
    assign atom_count = count_reg;
    assign too_many   = many_reg;
endmodule
`default_nettype wire

@@ src/regression_slope_octkey.sv @@
// Least-squares slope octree key.
// Input channel (in_valid/in_stall): one atom per transfer, signed Q10.10
// x_coord, y_coord, z_coord, and last_atom on the final atom of a conformation.
// Atoms are taken one per cycle while in_stall is low. A last atom snapshots
// the sums into a two-entry queue and clears the accumulators at once.
// The back end takes a snapshot only while idle, forms five product pairs in
// S_MUL, loads the remainders in S_INIT, resolves one key digit per level in
// S_LVL, and loads the output register in S_OUT before taking the next one.
// Output channel (out_valid/out_stall): octkey, atom_count, too_many. The
// result holds while out_stall is high; when the queue fills, in_stall rises.
// Config channel (cfg_valid/cfg_ready, always ready): digit_count, which the
// user writes only while idle; the block does not check. Reset clears all sums
// and the queue; digit_count resets to 15.
`default_nettype none
module regression_slope_octkey (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [rso_pkg::COORD_W-1:0]  x_coord,
    input  wire logic signed [rso_pkg::COORD_W-1:0]  y_coord,
    input  wire logic signed [rso_pkg::COORD_W-1:0]  z_coord,
    input  wire logic                                last_atom,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [rso_pkg::KEY_W-1:0]                octkey,
    output logic [rso_pkg::CNT_W-1:0]                atom_count,
    output logic                                     too_many,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rso_pkg::DIG_W-1:0]           digit_count
);
    logic [rso_pkg::DIG_W-1:0] digit_count_reg;
    logic           q_full, q_valid, push, pop;
    rso_pkg::snap_t push_data, pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            digit_count_reg <= rso_pkg::DIG_W'(rso_pkg::MAX_DIGITS);
        else if (cfg_valid && cfg_ready)
            digit_count_reg <= digit_count;
    end

    rso_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .z_coord   (z_coord),
        .last_atom (last_atom),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    rso_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .not_empty (q_valid),
        .pop       (pop),
        .pop_data  (pop_data)
    );

    rso_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (pop_data),
        .pop        (pop),
        .digits     (digit_count_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .octkey     (octkey),
        .atom_count (atom_count),
        .too_many   (too_many)
    );

    a_key_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (octkey >> (3 * {3'b0, digit_count_reg})) == '0)
        else $error("key bits above digit count");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (atom_count != '0
                   && atom_count <= rso_pkg::CNT_W'(rso_pkg::MAX_ATOMS)))
        else $error("atom count out of range");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push)
        else $error("push into full queue");
endmodule
`default_nettype wire
